// ===== hw/rtl/fractal_value_noise_assert.svh =====
// Assertion macros for the fractal value noise block.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef FRACTAL_VALUE_NOISE_ASSERT_SVH
`define FRACTAL_VALUE_NOISE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication under an active-low asynchronous reset
`define FVN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FVN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FVN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FVN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/fvn_pkg.sv =====
// Shared constants and types of the fractal value noise block.
// No dependencies.
package fvn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int COORD_W    = 32;
    localparam int NOISE_W    = 18;
    localparam int AMP_W      = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;
    localparam int OCT_W      = 4;

    localparam logic [AMP_W-1:0]  PERSIST_ONE   = 17'd65536;
    localparam logic [OCT_W-1:0]  OCT_RESET     = 4'd4;
    localparam logic [AMP_W-1:0]  PERSIST_RESET = 17'd32768;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Z = 32'd668265263;
    localparam logic [31:0] HASH_MUL_C = 32'd15731;
    localparam logic [31:0] HASH_ADD_A = 32'd789221;
    localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
    localparam int          HASH_SHIFT = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OCTAVE_COUNT = 4'd0,
        REG_PERSISTENCE  = 4'd1
    } cfg_reg_t;

endpackage

// ===== hw/rtl/fvn_if.sv =====
// Channel interfaces of the fractal value noise block: sample, result, config.
// Depends on fvn_pkg.
interface fvn_sample_if import fvn_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] z_coord;

    modport source (output valid, output x_coord, output z_coord, input ready);
    modport sink   (input valid, input x_coord, input z_coord, output ready);
endinterface

interface fvn_result_if import fvn_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [NOISE_W-1:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

interface fvn_cfg_if import fvn_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/fvn_cell.sv =====
// One octave cell: hashes the lattice corners, fades, blends and accumulates.
// Depends on fvn_pkg.
module fvn_cell import fvn_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
    parameter int OCTAVE      = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [$clog2(MAX_OCTAVES+1)-1:0] oct_eff,
    input  logic [AMP_W-1:0]              persist,
    input  logic                          in_valid,
    input  logic signed [COORD_W-1:0]     in_x,
    input  logic signed [COORD_W-1:0]     in_z,
    input  logic [AMP_W-1:0]              in_amp,
    input  logic signed [FRAC_BITS+17+$clog2(MAX_OCTAVES+1)-1:0] in_total,
    input  logic [16+$clog2(MAX_OCTAVES+1)-1:0] in_wsum,
    output logic                          out_valid,
    output logic signed [COORD_W-1:0]     out_x,
    output logic signed [COORD_W-1:0]     out_z,
    output logic [AMP_W-1:0]              out_amp,
    output logic signed [FRAC_BITS+17+$clog2(MAX_OCTAVES+1)-1:0] out_total,
    output logic [16+$clog2(MAX_OCTAVES+1)-1:0] out_wsum
);

    localparam int F   = FRAC_BITS;
    localparam int VW  = F + 2;
    localparam int OW  = $clog2(MAX_OCTAVES + 1);
    localparam int TW  = F + 17 + OW;
    localparam int WSW = 16 + OW;
    localparam int LAT = 8;

    function automatic logic signed [VW-1:0] blend(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b,
                                                   input logic [F:0] t);
        logic signed [VW:0]       diff;
        logic signed [VW+F+2:0]   prod;
        logic signed [VW+F+2:0]   shr;
        diff = {b[VW-1], b} - {a[VW-1], a};
        prod = $signed({1'b0, t}) * diff;
        shr  = prod >>> F;
        return a + shr[VW-1:0];
    endfunction

    // hand-off registers, one per stage
    logic [LAT-1:0]            v_reg;
    logic signed [COORD_W-1:0] x_reg     [LAT];
    logic signed [COORD_W-1:0] z_reg     [LAT];
    logic [AMP_W-1:0]          amp_reg   [LAT];
    logic signed [TW-1:0]      total_reg [LAT];
    logic [WSW-1:0]            wsum_reg  [LAT];

    // stage A: lattice split, corner products, fraction squares
    logic [63:0]   xs, zs;
    logic [31:0]   ix, iz;
    logic [F-1:0]  fx, fz;
    logic [2*F-1:0] fxsq, fzsq;
    logic [31:0]   pa0_next, pa1_next, pb0_next, pb1_next;
    logic [31:0]   pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic [F-1:0]  fx_reg, fz_reg, sqx_reg, sqz_reg;

    assign xs = {{32{in_x[31]}}, in_x} << OCTAVE;
    assign zs = {{32{in_z[31]}}, in_z} << OCTAVE;
    assign ix = xs[F+31:F];
    assign iz = zs[F+31:F];
    assign fx = xs[F-1:0];
    assign fz = zs[F-1:0];
    assign fxsq = fx * fx;
    assign fzsq = fz * fz;
    assign pa0_next = ix * HASH_MUL_X;
    assign pa1_next = (ix + 32'd1) * HASH_MUL_X;
    assign pb0_next = iz * HASH_MUL_Z;
    assign pb1_next = (iz + 32'd1) * HASH_MUL_Z;

    // stage B: corner seeds and fade
    logic [31:0]  n_sum  [4];
    logic [31:0]  n_next [4];
    logic [31:0]  n_b_reg [4];
    logic [F+1:0] kx, kz;
    logic [2*F+1:0] tx_full, tz_full;
    logic [F:0]   tx_b_reg, tz_b_reg;

    assign n_sum[0] = pa0_reg + pb0_reg;
    assign n_sum[1] = pa1_reg + pb0_reg;
    assign n_sum[2] = pa0_reg + pb1_reg;
    assign n_sum[3] = pa1_reg + pb1_reg;
    assign kx = ((F+2)'(3) << F) - {1'b0, fx_reg, 1'b0};
    assign kz = ((F+2)'(3) << F) - {1'b0, fz_reg, 1'b0};
    assign tx_full = sqx_reg * kx;
    assign tz_full = sqz_reg * kz;

    // stages C to E: hash polynomial
    logic [31:0] n_c_reg [4];
    logic [31:0] nn_reg  [4];
    logic [31:0] n_d_reg [4];
    logic [31:0] t_d_reg [4];
    logic [31:0] h_e     [4];
    logic signed [VW-1:0] cv_next [4];
    logic signed [VW-1:0] cv_reg  [4];
    logic [F:0] tx_c_reg, tz_c_reg, tx_d_reg, tz_d_reg, tx_e_reg, tz_e_reg;

    for (genvar c = 0; c < 4; c++) begin : g_corner
        assign n_next[c]  = n_sum[c] ^ (n_sum[c] << HASH_SHIFT);
        assign h_e[c]     = n_d_reg[c] * t_d_reg[c] + HASH_ADD_B;
        assign cv_next[c] = $signed(VW'(1) << F) - $signed({1'b0, h_e[c][30:30-F]});
    end

    // stages F to H: blends and weighted accumulation
    logic signed [VW-1:0] v0_reg, v1_reg, v_reg_g;
    logic [F:0]           tz_f_reg;
    logic signed [VW+17:0] wprod;
    logic [2*AMP_W-1:0]   amp_prod;
    logic                 active;
    logic signed [TW-1:0] total_next;
    logic [WSW-1:0]       wsum_next;
    logic [AMP_W-1:0]     amp_next;

    assign active   = OW'(OCTAVE) < oct_eff;
    assign wprod    = v_reg_g * $signed({1'b0, amp_reg[LAT-2]});
    assign amp_prod = amp_reg[LAT-2] * persist;

    always_comb
    begin
        total_next = total_reg[LAT-2];
        wsum_next  = wsum_reg[LAT-2];
        amp_next   = amp_reg[LAT-2];
        if (active)
        begin
            total_next = total_reg[LAT-2] + TW'(wprod);
            wsum_next  = wsum_reg[LAT-2] + WSW'(amp_reg[LAT-2]);
            amp_next   = amp_prod[AMP_W+15:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]     <= in_x;
            z_reg[0]     <= in_z;
            amp_reg[0]   <= in_amp;
            total_reg[0] <= in_total;
            wsum_reg[0]  <= in_wsum;
            for (int s = 1; s < LAT; s++)
            begin
                x_reg[s] <= x_reg[s-1];
                z_reg[s] <= z_reg[s-1];
            end
            for (int s = 1; s < LAT - 1; s++)
            begin
                amp_reg[s]   <= amp_reg[s-1];
                total_reg[s] <= total_reg[s-1];
                wsum_reg[s]  <= wsum_reg[s-1];
            end
            amp_reg[LAT-1]   <= amp_next;
            total_reg[LAT-1] <= total_next;
            wsum_reg[LAT-1]  <= wsum_next;

            pa0_reg <= pa0_next;
            pa1_reg <= pa1_next;
            pb0_reg <= pb0_next;
            pb1_reg <= pb1_next;
            fx_reg  <= fx;
            fz_reg  <= fz;
            sqx_reg <= fxsq[2*F-1:F];
            sqz_reg <= fzsq[2*F-1:F];

            tx_b_reg <= tx_full[2*F:F];
            tz_b_reg <= tz_full[2*F:F];
            tx_c_reg <= tx_b_reg;
            tz_c_reg <= tz_b_reg;
            tx_d_reg <= tx_c_reg;
            tz_d_reg <= tz_c_reg;
            tx_e_reg <= tx_d_reg;
            tz_e_reg <= tz_d_reg;
            for (int c = 0; c < 4; c++)
            begin
                n_b_reg[c] <= n_next[c];
                n_c_reg[c] <= n_b_reg[c];
                nn_reg[c]  <= n_b_reg[c] * n_b_reg[c];
                n_d_reg[c] <= n_c_reg[c];
                t_d_reg[c] <= nn_reg[c] * HASH_MUL_C + HASH_ADD_A;
                cv_reg[c]  <= cv_next[c];
            end

            v0_reg   <= blend(cv_reg[0], cv_reg[1], tx_e_reg);
            v1_reg   <= blend(cv_reg[2], cv_reg[3], tx_e_reg);
            tz_f_reg <= tz_e_reg;
            v_reg_g  <= blend(v0_reg, v1_reg, tz_f_reg);
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign out_x     = x_reg[LAT-1];
    assign out_z     = z_reg[LAT-1];
    assign out_amp   = amp_reg[LAT-1];
    assign out_total = total_reg[LAT-1];
    assign out_wsum  = wsum_reg[LAT-1];

endmodule

// ===== hw/rtl/fvn_div.sv =====
// Pipelined restoring divider: weighted sum over weight sum, one quotient bit
// per stage, then sign, saturation and output formatting. Depends on fvn_pkg.
module fvn_div import fvn_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [FRAC_BITS+17+$clog2(MAX_OCTAVES+1)-1:0] in_total,
    input  logic [16+$clog2(MAX_OCTAVES+1)-1:0] in_wsum,
    output logic                          out_valid,
    output logic signed [NOISE_W-1:0]     out_value
);

    localparam int F   = FRAC_BITS;
    localparam int OW  = $clog2(MAX_OCTAVES + 1);
    localparam int TW  = F + 17 + OW;
    localparam int WSW = 16 + OW;
    localparam int QW  = F + 1;
    localparam int RW  = F + 2;
    localparam int XW  = 27;

    logic [QW:0]    vld_reg;
    logic [TW-1:0]  rem_reg [QW+1];
    logic [WSW-1:0] d_reg   [QW+1];
    logic [QW-1:0]  q_reg   [QW+1];
    logic           neg_reg [QW+1];

    logic [TW-1:0]  rem_next [QW];
    logic [QW-1:0]  q_next   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [TW-1:0] dsh;
        assign dsh = TW'(d_reg[k]) << (QW - 1 - k);
        always_comb
        begin
            rem_next[k] = rem_reg[k];
            q_next[k]   = q_reg[k];
            if (rem_reg[k] >= dsh)
            begin
                rem_next[k]           = rem_reg[k] - dsh;
                q_next[k][QW - 1 - k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[QW-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= in_total[TW-1] ? TW'(-in_total) : TW'(in_total);
            d_reg[0]   <= in_wsum;
            q_reg[0]   <= '0;
            neg_reg[0] <= in_total[TW-1];
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                d_reg[k+1]   <= d_reg[k];
                q_reg[k+1]   <= q_next[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // saturate the magnitude to one, apply the sign, keep the low output bits
    logic [QW-1:0]        qsat;
    logic signed [RW-1:0] r;
    logic signed [XW-1:0] rx;

    assign qsat = (q_reg[QW] > (QW'(1) << F)) ? (QW'(1) << F) : q_reg[QW];
    assign r    = neg_reg[QW] ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
    assign rx   = {{(XW-RW){r[RW-1]}}, r};

    assign out_valid = vld_reg[QW];
    assign out_value = rx[NOISE_W-1:0];

endmodule

// ===== hw/rtl/fractal_value_noise.sv =====
// Top level of the fractal value noise generator: config registers, the row
// of octave cells, the divider and the result register. Depends on fvn_pkg,
// fvn_if, fvn_cell, fvn_div and fractal_value_noise_assert.svh.
//
// Channel  Dir  Payload                      Request taken when
// sample   in   x_coord, z_coord (Q16.16)    sample.valid & sample.ready
// result   out  noise_value (Q1.16, 18 bit)  result.valid & result.ready
// cfg      in   index, data                  cfg.valid & cfg.ready (always ready)
//
// One request enters per cycle while the pipe is not stalled. A request passes
// through the cells, then the divider stages, then the result register.
// Each cell always spends its eight stages; unused octaves pass the sums on.
// Reset clears only valid bits and the config registers (octave_count 4,
// persistence 0.5); no clearing pass. A stall halts the whole pipe only when
// a finished result meets a full result register that is not being taken.
`include "fractal_value_noise_assert.svh"

module fractal_value_noise import fvn_pkg::*; #(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fvn_sample_if.sink   sample,
    fvn_result_if.source result,
    fvn_cfg_if.sink      cfg
);

    localparam int OW  = $clog2(MAX_OCTAVES + 1);
    localparam int TW  = FRAC_BITS + 17 + OW;
    localparam int WSW = 16 + OW;

    // configuration registers
    logic [OCT_W-1:0] oct_reg;
    logic [AMP_W-1:0] persist_reg;
    logic [OW-1:0]    oct_eff;
    logic [AMP_W-1:0] persist_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg     <= OCT_RESET;
            persist_reg <= PERSIST_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_OCTAVE_COUNT: oct_reg     <= cfg.data[OCT_W-1:0];
                REG_PERSISTENCE:  persist_reg <= cfg.data[AMP_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp the octave count to [1, MAX_OCTAVES] and persistence to one
    always_comb
    begin
        if (oct_reg == '0)
            oct_eff = OW'(1);
        else if (int'(oct_reg) > MAX_OCTAVES)
            oct_eff = OW'(MAX_OCTAVES);
        else
            oct_eff = OW'(oct_reg);
    end

    assign persist_eff = (persist_reg > PERSIST_ONE) ? PERSIST_ONE : persist_reg;

    // pipeline advance: hold only when a finished result has nowhere to go
    logic                      adv;
    logic                      div_valid;
    logic signed [NOISE_W-1:0] div_value;
    logic                      out_valid_reg;
    logic signed [NOISE_W-1:0] out_value_reg;

    assign adv          = !(div_valid && out_valid_reg && !result.ready);
    assign sample.ready = adv;

    // row of octave cells, each handing coordinates and running sums onward
    logic                      ch_valid [MAX_OCTAVES+1];
    logic signed [COORD_W-1:0] ch_x     [MAX_OCTAVES+1];
    logic signed [COORD_W-1:0] ch_z     [MAX_OCTAVES+1];
    logic [AMP_W-1:0]          ch_amp   [MAX_OCTAVES+1];
    logic signed [TW-1:0]      ch_total [MAX_OCTAVES+1];
    logic [WSW-1:0]            ch_wsum  [MAX_OCTAVES+1];

    assign ch_valid[0] = sample.valid;
    assign ch_x[0]     = sample.x_coord;
    assign ch_z[0]     = sample.z_coord;
    assign ch_amp[0]   = PERSIST_ONE;
    assign ch_total[0] = '0;
    assign ch_wsum[0]  = '0;

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
        fvn_cell #(
            .FRAC_BITS   (FRAC_BITS),
            .MAX_OCTAVES (MAX_OCTAVES),
            .OCTAVE      (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .oct_eff   (oct_eff),
            .persist   (persist_eff),
            .in_valid  (ch_valid[i]),
            .in_x      (ch_x[i]),
            .in_z      (ch_z[i]),
            .in_amp    (ch_amp[i]),
            .in_total  (ch_total[i]),
            .in_wsum   (ch_wsum[i]),
            .out_valid (ch_valid[i+1]),
            .out_x     (ch_x[i+1]),
            .out_z     (ch_z[i+1]),
            .out_amp   (ch_amp[i+1]),
            .out_total (ch_total[i+1]),
            .out_wsum  (ch_wsum[i+1])
        );
    end

    fvn_div #(
        .FRAC_BITS   (FRAC_BITS),
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ch_valid[MAX_OCTAVES]),
        .in_total  (ch_total[MAX_OCTAVES]),
        .in_wsum   (ch_wsum[MAX_OCTAVES]),
        .out_valid (div_valid),
        .out_value (div_value)
    );

    // result register: load a finished sample, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && div_valid)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && div_valid)
            out_value_reg <= div_value;
    end

    assign result.valid       = out_valid_reg;
    assign result.noise_value = out_value_reg;

    // a stalled pipe keeps its finished sample
    `FVN_ASSERT_NXT(a_stall_keeps, clk, rst_n, !adv, div_valid, "stalled sample lost")
    // a finished sample always lands in the result register
    `FVN_ASSERT_NXT(a_load, clk, rst_n, adv && div_valid, out_valid_reg, "result not loaded")
    // the first octave always contributes, so the weight sum is never zero
    `FVN_ASSERT_IMP(a_wsum, clk, rst_n, ch_valid[MAX_OCTAVES], ch_wsum[MAX_OCTAVES] != '0, "zero weight sum")

endmodule
